[design/qmn_pkg.sv]
// Shared types and widths for the normalized quaternion product pipeline.
package qmn_pkg;

  localparam int CompBits  = 16;
  localparam int FracBits  = CompBits - 2;
  localparam int ProdBits  = 2 * CompBits;
  localparam int CBits     = ProdBits + 2;
  localparam int MagBits   = ProdBits + 1;
  localparam int SumBits   = 2 * ProdBits + 1;
  localparam int RootSteps = (SumBits + 1) / 2;
  localparam int RootBits  = RootSteps;
  localparam int RadBits   = 2 * RootSteps;
  localparam int RemBits   = RootBits + 2;
  localparam int QuotBits  = FracBits + 1;
  localparam int NumBits   = MagBits + FracBits;

  typedef logic signed [CompBits-1:0] comp_t;
  typedef logic signed [CBits-1:0]    cval_t;
  typedef logic [MagBits-1:0]         mag_t;

  typedef struct packed {
    comp_t a_x;
    comp_t a_y;
    comp_t a_z;
    comp_t a_w;
    comp_t b_x;
    comp_t b_y;
    comp_t b_z;
    comp_t b_w;
  } in_req_t;

  typedef struct packed {
    comp_t r_x;
    comp_t r_y;
    comp_t r_z;
    comp_t r_w;
    logic  zero_norm;
  } out_req_t;

  // Product magnitudes and signs that ride along with the norm computation.
  typedef struct packed {
    logic [3:0]              neg;
    logic [3:0][MagBits-1:0] mag;
    logic                    zero;
  } norm_ctl_t;

  typedef struct packed {
    logic [SumBits-1:0] sum;
    norm_ctl_t          ctl;
  } sum_req_t;

  typedef struct packed {
    logic [RootBits-1:0] root;
    norm_ctl_t           ctl;
  } root_req_t;

endpackage

[design/qmn_align.sv]
// Block alignment stage: scales each quaternion so its largest magnitude uses 15 bits.
module qmn_align (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  qmn_pkg::in_req_t in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output qmn_pkg::in_req_t out_req_o
);

  localparam int MagW = qmn_pkg::CompBits - 1;
  localparam int LzW  = $clog2(MagW + 1);

  qmn_pkg::comp_t   qa [4];
  qmn_pkg::comp_t   qb [4];
  qmn_pkg::comp_t   sa [4];
  qmn_pkg::comp_t   sb [4];
  logic [MagW-1:0]  or_a, or_b;
  logic [LzW-1:0]   lz_a, lz_b;
  logic             v_q;
  qmn_pkg::in_req_t req_q;

  assign qa[0] = in_req_i.a_x;
  assign qa[1] = in_req_i.a_y;
  assign qa[2] = in_req_i.a_z;
  assign qa[3] = in_req_i.a_w;
  assign qb[0] = in_req_i.b_x;
  assign qb[1] = in_req_i.b_y;
  assign qb[2] = in_req_i.b_z;
  assign qb[3] = in_req_i.b_w;

  always_comb begin
    or_a = '0;
    or_b = '0;
    for (int i = 0; i < 4; i++) begin
      // magnitude of a negative value is -v-1, i.e. the inverted low bits
      or_a |= qa[i][MagW] ? ~qa[i][MagW-1:0] : qa[i][MagW-1:0];
      or_b |= qb[i][MagW] ? ~qb[i][MagW-1:0] : qb[i][MagW-1:0];
    end
    lz_a = LzW'(MagW);
    lz_b = LzW'(MagW);
    for (int i = 0; i < MagW; i++) begin
      if (or_a[i]) lz_a = LzW'(MagW - 1 - i);
      if (or_b[i]) lz_b = LzW'(MagW - 1 - i);
    end
    for (int i = 0; i < 4; i++) begin
      sa[i] = qa[i] <<< lz_a;
      sb[i] = qb[i] <<< lz_b;
    end
  end

  assign in_ready_o = ~v_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      req_q <= '{a_x: sa[0], a_y: sa[1], a_z: sa[2], a_w: sa[3],
                 b_x: sb[0], b_y: sb[1], b_z: sb[2], b_w: sb[3]};
    end
  end

  assign out_valid_o = v_q;
  assign out_req_o   = req_q;

endmodule

[design/qmn_product.sv]
// Hamilton product, magnitudes and sum of squares over four register stages.
module qmn_product (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  qmn_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output qmn_pkg::sum_req_t out_req_o
);

  localparam int NStage = 4;
  localparam int PB     = qmn_pkg::ProdBits;

  logic [NStage-1:0] v_q;
  logic [NStage:0]   en;

  qmn_pkg::comp_t          a [4];
  qmn_pkg::comp_t          b [4];
  logic signed [PB-1:0]    p_q [4][4];
  qmn_pkg::cval_t          c [4];
  qmn_pkg::norm_ctl_t      ctl_d, ctl2_q, ctl3_q, ctl4_q;
  logic [2*PB-1:0]         sq_lo [4];
  logic [qmn_pkg::SumBits-1:0] sq_d [4];
  logic [qmn_pkg::SumBits-1:0] sq_q [4];
  logic [qmn_pkg::SumBits-1:0] sum_q;

  assign a[0] = in_req_i.a_x;
  assign a[1] = in_req_i.a_y;
  assign a[2] = in_req_i.a_z;
  assign a[3] = in_req_i.a_w;
  assign b[0] = in_req_i.b_x;
  assign b[1] = in_req_i.b_y;
  assign b[2] = in_req_i.b_z;
  assign b[3] = in_req_i.b_w;

  // per-stage elastic handshake
  assign en[NStage] = out_ready_i;
  for (genvar k = 0; k < NStage; k++) begin : g_en
    assign en[k] = ~v_q[k] | en[k+1];
  end
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NStage; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 1: all sixteen partial products
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          p_q[i][j] <= a[i] * b[j];
        end
      end
    end
  end

  // stage 2: combine into components, take magnitude and sign
  always_comb begin
    c[0] = qmn_pkg::cval_t'(p_q[1][2]) - qmn_pkg::cval_t'(p_q[2][1])
         + qmn_pkg::cval_t'(p_q[3][0]) + qmn_pkg::cval_t'(p_q[0][3]);
    c[1] = qmn_pkg::cval_t'(p_q[2][0]) - qmn_pkg::cval_t'(p_q[0][2])
         + qmn_pkg::cval_t'(p_q[3][1]) + qmn_pkg::cval_t'(p_q[1][3]);
    c[2] = qmn_pkg::cval_t'(p_q[0][1]) - qmn_pkg::cval_t'(p_q[1][0])
         + qmn_pkg::cval_t'(p_q[3][2]) + qmn_pkg::cval_t'(p_q[2][3]);
    c[3] = qmn_pkg::cval_t'(p_q[3][3]) - qmn_pkg::cval_t'(p_q[0][0])
         - qmn_pkg::cval_t'(p_q[1][1]) - qmn_pkg::cval_t'(p_q[2][2]);
    ctl_d.zero = 1'b1;
    for (int i = 0; i < 4; i++) begin
      ctl_d.neg[i] = c[i] < 0;
      ctl_d.mag[i] = qmn_pkg::mag_t'((c[i] < 0) ? -c[i] : c[i]);
      if (c[i] != 0) ctl_d.zero = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) ctl2_q <= ctl_d;
  end

  // stage 3: squares; a magnitude of 2^32 is the only one needing bit 32
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sq_lo[i] = ctl2_q.mag[i][PB-1:0] * ctl2_q.mag[i][PB-1:0];
      sq_d[i]  = ctl2_q.mag[i][PB] ? {1'b1, {(2*PB){1'b0}}} : {1'b0, sq_lo[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      sq_q   <= sq_d;
      ctl3_q <= ctl2_q;
    end
  end

  // stage 4: sum of squares (never exceeds 2^64)
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      sum_q  <= sq_q[0] + sq_q[1] + sq_q[2] + sq_q[3];
      ctl4_q <= ctl3_q;
    end
  end

  assign out_valid_o   = v_q[NStage-1];
  assign out_req_o.sum = sum_q;
  assign out_req_o.ctl = ctl4_q;

endmodule

[design/qmn_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
module qmn_isqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  qmn_pkg::sum_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output qmn_pkg::root_req_t out_req_o
);

  localparam int NStage = qmn_pkg::RootSteps;
  localparam int RadW   = qmn_pkg::RadBits;
  localparam int RemW   = qmn_pkg::RemBits;
  localparam int RootW  = qmn_pkg::RootBits;

  typedef struct packed {
    logic [RadW-1:0]    rad;
    logic [RemW-1:0]    rem;
    logic [RootW-1:0]   root;
    qmn_pkg::norm_ctl_t ctl;
  } sq_stage_t;

  logic [NStage-1:0] v_q;
  logic [NStage:0]   en;
  sq_stage_t         st_q [NStage];
  sq_stage_t         init;

  assign init.rad  = RadW'(in_req_i.sum);
  assign init.rem  = '0;
  assign init.root = '0;
  assign init.ctl  = in_req_i.ctl;

  assign en[NStage] = out_ready_i;
  for (genvar k = 0; k < NStage; k++) begin : g_en
    assign en[k] = ~v_q[k] | en[k+1];
  end
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NStage; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  for (genvar k = 0; k < NStage; k++) begin : g_step
    sq_stage_t       prev, nxt;
    logic [RemW-1:0] rem_sh, trial;

    if (k == 0) begin : g_first
      assign prev = init;
    end else begin : g_next
      assign prev = st_q[k-1];
    end

    always_comb begin
      rem_sh   = {prev.rem[RemW-3:0], prev.rad[RadW-1 -: 2]};
      trial    = {prev.root, 2'b01};
      nxt      = prev;
      nxt.rad  = prev.rad << 2;
      if (rem_sh >= trial) begin
        nxt.rem  = rem_sh - trial;
        nxt.root = {prev.root[RootW-2:0], 1'b1};
      end else begin
        nxt.rem  = rem_sh;
        nxt.root = {prev.root[RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) st_q[k] <= nxt;
    end
  end

  assign out_valid_o    = v_q[NStage-1];
  assign out_req_o.root = st_q[NStage-1].root;
  assign out_req_o.ctl  = st_q[NStage-1].ctl;

endmodule

[design/qmn_divide.sv]
// Four restoring dividers in lockstep, rounding, saturation and sign restore.
module qmn_divide (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  qmn_pkg::root_req_t in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output qmn_pkg::out_req_t  out_req_o
);

  localparam int QB     = qmn_pkg::QuotBits;
  localparam int NB     = qmn_pkg::NumBits;
  localparam int FB     = qmn_pkg::FracBits;
  localparam int CB     = qmn_pkg::CompBits;
  localparam int RootW  = qmn_pkg::RootBits;
  localparam int NStage = QB + 2;

  typedef struct packed {
    logic [3:0][NB-1:0] rem;
    logic [3:0][QB-1:0] quo;
    logic [RootW-1:0]   den;
    logic [3:0]         neg;
    logic               zero;
  } div_stage_t;

  logic [NStage-1:0] v_q;
  logic [NStage:0]   en;
  div_stage_t        st_q [NStage-1];
  div_stage_t        prep;
  qmn_pkg::out_req_t res_d, res_q;

  assign en[NStage] = out_ready_i;
  for (genvar k = 0; k < NStage; k++) begin : g_en
    assign en[k] = ~v_q[k] | en[k+1];
  end
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NStage; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // numerator = mag * 2^F + floor(n/2)
  always_comb begin
    prep.den  = in_req_i.root;
    prep.neg  = in_req_i.ctl.neg;
    prep.zero = in_req_i.ctl.zero;
    prep.quo  = '0;
    for (int i = 0; i < 4; i++) begin
      prep.rem[i] = {in_req_i.ctl.mag[i], {FB{1'b0}}} + NB'(in_req_i.root >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) st_q[0] <= prep;
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    localparam int Sh = QB - k;
    div_stage_t      nxt;
    logic [NB:0]     dsh;

    assign dsh = (NB + 1)'(st_q[k-1].den) << Sh;

    always_comb begin
      nxt = st_q[k-1];
      for (int i = 0; i < 4; i++) begin
        if ({1'b0, st_q[k-1].rem[i]} >= dsh) begin
          nxt.rem[i]     = st_q[k-1].rem[i] - dsh[NB-1:0];
          nxt.quo[i][Sh] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) st_q[k] <= nxt;
    end
  end

  // saturate to one, restore sign, force zero for a null product
  always_comb begin
    logic [QB-1:0]       q;
    logic signed [CB-1:0] r [4];
    for (int i = 0; i < 4; i++) begin
      q = st_q[QB].quo[i];
      if (q > {1'b1, {FB{1'b0}}}) q = {1'b1, {FB{1'b0}}};
      r[i] = st_q[QB].neg[i] ? -CB'(q) : CB'(q);
      if (st_q[QB].zero) r[i] = '0;
    end
    res_d.r_x       = r[0];
    res_d.r_y       = r[1];
    res_d.r_z       = r[2];
    res_d.r_w       = r[3];
    res_d.zero_norm = st_q[QB].zero;
  end

  always_ff @(posedge clk_i) begin
    if (en[NStage-1]) res_q <= res_d;
  end

  assign out_valid_o = v_q[NStage-1];
  assign out_req_o   = res_q;

endmodule

[design/quaternion_multiply_normalize_core.sv]
// Top level: normalized Hamilton quaternion product, fixed-point pipeline.
//
// Input channel (in_valid_i / in_ready_o / in_req_i): one request holds two
// quaternions a and b, each component signed Q1.14. Output channel
// (out_valid_o / out_ready_i / out_req_o): the unit-length product a*b,
// components rounded half away from zero and clamped to [-1, 1], plus
// zero_norm when the product is exactly zero (components then read 0).
// Every input request yields exactly one output request, in order.
// Pipeline registers from acceptance to out_valid_o:
//   1 alignment, 4 product/square/sum, 33 square root (one root bit per
//   stage), 17 divide (prep, 15 quotient bits, format/output register).
// Throughput: one request per cycle while out_ready_i is high; every stage
// is a register with its own valid bit, so bubbles are squeezed out and a
// full pipeline still takes a new request in the cycle its output is taken.
// Stall: with out_ready_i low the output holds; upstream stages keep
// filling until every stage is occupied, then in_ready_o drops.
// Reset (rst_ni low, asynchronous): all valid bits clear, nothing in flight.
module quaternion_multiply_normalize_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  qmn_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output qmn_pkg::out_req_t out_req_o
);

  // alignment -> product
  logic               al_valid, al_ready;
  qmn_pkg::in_req_t   al_req;
  // product -> square root
  logic               pr_valid, pr_ready;
  qmn_pkg::sum_req_t  pr_req;
  // square root -> divide
  logic               rt_valid, rt_ready;
  qmn_pkg::root_req_t rt_req;

  qmn_align u_align (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (al_valid),
    .out_ready_i (al_ready),
    .out_req_o   (al_req)
  );

  qmn_product u_product (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (al_valid),
    .in_ready_o  (al_ready),
    .in_req_i    (al_req),
    .out_valid_o (pr_valid),
    .out_ready_i (pr_ready),
    .out_req_o   (pr_req)
  );

  qmn_isqrt u_isqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pr_valid),
    .in_ready_o  (pr_ready),
    .in_req_i    (pr_req),
    .out_valid_o (rt_valid),
    .out_ready_i (rt_ready),
    .out_req_o   (rt_req)
  );

  // divide stage ends in the output register
  qmn_divide u_divide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rt_valid),
    .in_ready_o  (rt_ready),
    .in_req_i    (rt_req),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

`ifndef SYNTHESIS
  // input backs up only when the whole pipeline is full behind a stalled output
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.zero_norm |->
      out_req_o.r_x == 0 && out_req_o.r_y == 0 &&
      out_req_o.r_z == 0 && out_req_o.r_w == 0)
    else $error("zero_norm with nonzero components");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_req_o.r_x <= 16384 && out_req_o.r_x >= -16384 &&
      out_req_o.r_y <= 16384 && out_req_o.r_y >= -16384 &&
      out_req_o.r_z <= 16384 && out_req_o.r_z >= -16384 &&
      out_req_o.r_w <= 16384 && out_req_o.r_w >= -16384)
    else $error("component outside [-1, 1]");
`endif

endmodule
